[rtl/core/ibid_pkg.sv]
// Shared types and constants for the inode block index decomposer.
package ibid_pkg;

  localparam int unsigned IdxW = 32;
  localparam int unsigned KbW = 5;
  localparam int unsigned EpbW = 11;
  localparam int unsigned PtrW = 13;
  localparam int unsigned OffW = 10;

  localparam logic RegBlockSizeKb = 1'b0;
  localparam logic RegEntriesPerBlock = 1'b1;

  typedef struct packed {
    logic [1:0]      level;
    logic [2:0]      inode_slot;
    logic [PtrW-1:0] first_ptr_index;
    logic [PtrW-1:0] second_ptr_index;
    logic [PtrW-1:0] third_ptr_index;
    logic [OffW-1:0] entry_offset;
    logic [2:0]      index_block_starts;
    logic            overflow;
  } result_t;

endpackage

[rtl/core/ibid_if.sv]
// Valid/ready channel interface carrying one payload beat.
interface ibid_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/ibid_divider.sv]
// Restoring divider stage that resolves one quotient bit.
module ibid_divider #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 64,
  parameter int unsigned Bit  = 0
) (
  input  logic [NumW-1:0] rem_in,
  input  logic [DenW-1:0] den,
  output logic [NumW-1:0] rem_out,
  output logic            q_bit
);
  logic [NumW+DenW-1:0] shifted;
  logic [NumW+DenW-1:0] ext_rem;

  always_comb begin
    shifted = {{NumW{1'b0}}, den} << Bit;
    ext_rem = {{DenW{1'b0}}, rem_in};
    q_bit = ext_rem >= shifted;
    rem_out = q_bit ? NumW'(ext_rem - shifted) : rem_in;
  end
endmodule

[rtl/core/inode_block_index_decompose.sv]
// Top level of the inode block index decomposer.
//
// The block splits a 32-bit logical index of a file along the inode's direct,
// single-, double- and triple-indirect pointer tree. One beat can enter every
// cycle unless the output stalls or the span table is settling. An accepted
// index passes a level-select register, then four chained digit extractions
// (slot, then one per indirect level) that each run as a restoring division,
// one quotient bit per pipeline stage, and finally an output register:
// 4*IdxW+2 registers in all. The pipeline advances whenever its last stage
// is empty or being taken, so a stalled output holds every stage in place and
// nothing is lost or repeated. The span table behind the level select is
// built from the two configuration registers over four registered steps, so
// the input is held off (ready low) after reset and after every register
// write until the settle count has run out. The registers must only be
// written while the pipeline is empty.
module inode_block_index_decompose #(
  parameter int unsigned DIRECT_SLOTS = 8,
  parameter int unsigned SINGLE_SLOTS = 1,
  parameter int unsigned DOUBLE_SLOTS = 1,
  parameter int unsigned TRIPLE_SLOTS = 1,
  parameter int unsigned ADDR_BYTES   = 2
) (
  input  logic        clk,
  input  logic        rst,
  ibid_if.sink        in_ch,
  ibid_if.source      out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ibid_pkg::*;

  // Remainders stay below span*slots, which fits in 64 bits.
  localparam int unsigned WW = 64;
  localparam int unsigned DivSteps = IdxW;
  localparam int unsigned Levels = 4;
  localparam int unsigned NStg = Levels * DivSteps;
  localparam logic [2:0] SettleCycles = 3'd4;

  logic [KbW-1:0]  block_size_kb;
  logic [EpbW-1:0] entries_per_block;
  logic [2:0]      settle;

  assign pready = 1'b1;

  // A register write restarts the settle count so that no index is taken
  // before the span table reflects the new geometry.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size_kb <= KbW'(1);
      entries_per_block <= EpbW'(1);
      settle <= SettleCycles;
    end else if (psel && penable && pwrite) begin
      settle <= SettleCycles;
      unique case (paddr[2])
        RegBlockSizeKb: block_size_kb <= pwdata[KbW-1:0];
        RegEntriesPerBlock: entries_per_block <= pwdata[EpbW-1:0];
      endcase
    end else if (settle != 3'd0) begin
      settle <= settle - 3'd1;
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegBlockSizeKb: prdata = 32'(block_size_kb);
      RegEntriesPerBlock: prdata = 32'(entries_per_block);
    endcase
  end

  // Clamped configuration and span table. The multiplies are small (15x11 and
  // chained by pointer counts up to 2^14), but they run off static registers,
  // so each step is registered. The pointer count per indirect block comes
  // from a small constant table.
  logic [4:0]    kb_c;
  logic [10:0]   c_c;
  logic [14:0]   ptrs;
  logic [WW-1:0] span0, span1, span2, span3;
  logic [WW-1:0] span1_n, span2_n, span3_n;

  always_comb begin
    kb_c = (block_size_kb == '0) ? 5'd1 : (block_size_kb > 5'd16) ? 5'd16 : block_size_kb;
    c_c = (entries_per_block == '0) ? 11'd1 :
          (entries_per_block > 11'd1024) ? 11'd1024 : entries_per_block;
    ptrs = '0;
    for (int k = 1; k <= 16; k++) begin
      if (kb_c == 5'(k)) ptrs = 15'((k * 1024) / ADDR_BYTES);
    end
  end

  always_ff @(posedge clk) begin
    span0 <= WW'(c_c);
    span1 <= span1_n;
    span2 <= span2_n;
    span3 <= span3_n;
  end

  assign span1_n = WW'(c_c * ptrs);
  assign span2_n = WW'(span1[25:0] * ptrs);
  assign span3_n = WW'(span2[40:0] * ptrs);

  // Pipeline control.
  logic advance;
  logic [NStg+1:0] vld;
  assign advance = !vld[NStg+1] || out_ch.ready;
  assign in_ch.ready = advance && (settle == 3'd0);

  // Stage A: level selection against registered region sizes.
  logic [WW-1:0] rg0, rg1, rg2, rg3;
  logic [WW-1:0] b1, b2, b3;
  always_ff @(posedge clk) begin
    rg0 <= span0 * WW'(DIRECT_SLOTS);
    rg1 <= span1 * WW'(SINGLE_SLOTS);
    rg2 <= span2 * WW'(DOUBLE_SLOTS);
    rg3 <= span3 * WW'(TRIPLE_SLOTS);
  end
  assign b1 = rg0;
  assign b2 = rg0 + rg1;
  assign b3 = b2 + rg2;

  logic [WW-1:0] n_w;
  logic [1:0]    lvl_n;
  logic          ovf_n;
  logic [WW-1:0] r_n;
  assign n_w = WW'(in_ch.payload);

  always_comb begin
    lvl_n = 2'd0;
    ovf_n = 1'b0;
    r_n = '0;
    priority if (n_w < b1) begin
      lvl_n = 2'd0; r_n = n_w;
    end else if (n_w - b1 < rg1) begin
      lvl_n = 2'd1; r_n = n_w - b1;
    end else if (n_w - b2 < rg2) begin
      lvl_n = 2'd2; r_n = n_w - b2;
    end else if (n_w - b3 < rg3) begin
      lvl_n = 2'd3; r_n = n_w - b3;
    end else begin
      ovf_n = 1'b1;
    end
  end

  // Divider chain: digit d (0 slot, 1..3 pointers) divides by span[lvl-d].
  logic [WW-1:0] rem  [NStg+1];
  logic [IdxW-1:0] q  [NStg+1];
  logic [1:0]    lv   [NStg+1];
  logic          ov   [NStg+1];
  logic [IdxW-1:0] dg [NStg+1][Levels];
  logic [2:0]    st   [NStg+1];

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (advance) vld[0] <= in_ch.valid && in_ch.ready;
    if (advance) begin
      rem[0] <= r_n; lv[0] <= lvl_n; ov[0] <= ovf_n; q[0] <= '0; st[0] <= '0;
      for (int d = 0; d < Levels; d++) dg[0][d] <= '0;
    end
  end

  function automatic logic [WW-1:0] sel_span(input logic [1:0] l, input int unsigned d,
      input logic [WW-1:0] s0, input logic [WW-1:0] s1, input logic [WW-1:0] s2,
      input logic [WW-1:0] s3);
    logic [2:0] idx;
    idx = 3'(l) - 3'(d);
    unique case (idx)
      3'd0: sel_span = s0;
      3'd1: sel_span = s1;
      3'd2: sel_span = s2;
      3'd3: sel_span = s3;
      default: sel_span = '1;
    endcase
  endfunction

  for (genvar s = 0; s < NStg; s++) begin : g_stage
    localparam int unsigned D = s / DivSteps;
    localparam int unsigned B = DivSteps - 1 - (s % DivSteps);
    localparam logic [2:0] StBit = 3'((1 << D) >> 1);
    logic [WW-1:0]   den, rem_o;
    logic            qb, active;
    logic [IdxW-1:0] q_acc;
    logic [2:0]      st_n;
    assign active = (D == 0) || (32'(lv[s]) >= D);
    assign den = sel_span(lv[s], D, span0, span1, span2, span3);
    ibid_divider #(.NumW(WW), .DenW(WW), .Bit(B)) u_div (
      .rem_in(rem[s]), .den(den), .rem_out(rem_o), .q_bit(qb)
    );
    always_comb begin
      q_acc = (B == DivSteps - 1) ? IdxW'(qb) : {q[s][IdxW-2:0], qb};
      st_n = st[s];
      // Start of a digit: record whether the remaining part is zero.
      if (B == DivSteps - 1 && active && rem[s] == '0) st_n = st[s] | StBit;
    end
    always_ff @(posedge clk) begin
      if (rst) vld[s+1] <= 1'b0;
      else if (advance) vld[s+1] <= vld[s];
      if (advance) begin
        lv[s+1] <= lv[s];
        ov[s+1] <= ov[s];
        st[s+1] <= st_n;
        rem[s+1] <= active ? rem_o : rem[s];
        q[s+1] <= active ? q_acc : '0;
        for (int d = 0; d < Levels; d++) begin
          if (B == 0 && d == D) dg[s+1][d] <= active ? q_acc : '0;
          else dg[s+1][d] <= dg[s][d];
        end
      end
    end
  end

  // Output register.
  result_t res;
  result_t res_n;
  always_comb begin
    res_n = '0;
    if (ov[NStg]) begin
      res_n.overflow = 1'b1;
    end else begin
      res_n.level = lv[NStg];
      res_n.inode_slot = dg[NStg][0][2:0];
      res_n.first_ptr_index = dg[NStg][1][PtrW-1:0];
      res_n.second_ptr_index = dg[NStg][2][PtrW-1:0];
      res_n.third_ptr_index = dg[NStg][3][PtrW-1:0];
      res_n.entry_offset = rem[NStg][OffW-1:0];
      res_n.index_block_starts = st[NStg];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld[NStg+1] <= 1'b0;
    else if (advance) vld[NStg+1] <= vld[NStg];
    if (advance) res <= res_n;
  end

  assign out_ch.valid = vld[NStg+1];
  assign out_ch.payload = res;

  a_ovf_clean: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.payload.overflow |-> out_ch.payload.level == 2'd0 &&
      out_ch.payload.entry_offset == '0) else $error("overflow result not cleared");
  a_direct_starts: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.payload.level == 2'd0 |-> out_ch.payload.index_block_starts == '0)
    else $error("direct level flagged index block");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.payload))
    else $error("stalled result changed");
endmodule

[verif/inode_block_index_decompose_tb.sv]
// Testbench for the inode block index decomposer: directed and random indexes.
`timescale 1ns / 100ps

module inode_block_index_decompose_tb;
  import ibid_pkg::*;

  // Pipeline depth is 4*IdxW+2 beats; the drain pause after a phase covers it.
  localparam int unsigned Latency = 4 * IdxW + 2;
  localparam int unsigned DrainCycles = Latency + 20;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned LongStall = 300;

  // Tree shape of the default instance.
  localparam int unsigned NumDirect = 8;
  localparam int unsigned NumSingle = 1;
  localparam int unsigned NumDouble = 1;
  localparam int unsigned NumTriple = 1;
  localparam int unsigned PtrBytes = 2;

  // A small scoreboard: it holds the current register settings, predicts the
  // result of every accepted index and compares results in arrival order.
  class decompose_scoreboard;
    logic [KbW-1:0]  kb_reg;
    logic [EpbW-1:0] epb_reg;
    result_t         pending[$];
    int unsigned     n_errors;
    int unsigned     n_checked;
    int unsigned     level_seen[4];
    int unsigned     n_overflow;

    function new();
      kb_reg = 1;
      epb_reg = 1;
      n_errors = 0;
      n_checked = 0;
      n_overflow = 0;
      foreach (level_seen[i]) level_seen[i] = 0;
    endfunction

    function result_t decompose(logic [IdxW-1:0] idx);
      longint unsigned kb, units, ptrs, base, rem, region, n;
      longint unsigned span[4];
      longint unsigned slot_count[4];
      longint unsigned ptr_idx[3];
      result_t res;
      int lvl;
      bit hit;
      kb = kb_reg;
      units = epb_reg;
      res = '0;
      ptr_idx = '{0, 0, 0};
      hit = 0;
      lvl = 0;
      if (kb < 1) kb = 1;
      if (kb > 16) kb = 16;
      if (units < 1) units = 1;
      if (units > 1024) units = 1024;
      ptrs = (kb * 1024) / PtrBytes;
      span[0] = units;
      span[1] = units * ptrs;
      span[2] = span[1] * ptrs;
      span[3] = span[2] * ptrs;
      slot_count = '{NumDirect, NumSingle, NumDouble, NumTriple};
      n = idx;
      base = 0;
      for (int k = 0; k < 4; k++) begin
        region = span[k] * slot_count[k];
        if (!hit) begin
          if (n >= base && n - base < region) begin
            lvl = k;
            hit = 1;
          end else begin
            base += region;
          end
        end
      end
      if (!hit) begin
        res.overflow = 1'b1;
        return res;
      end
      rem = n - base;
      res.inode_slot = 3'(rem / span[lvl]);
      rem = rem % span[lvl];
      for (int k = 1; k <= lvl; k++) begin
        // An index block is first used when nothing lies before us inside it.
        if (rem == 0) res.index_block_starts[k-1] = 1'b1;
        ptr_idx[k-1] = rem / span[lvl-k];
        rem = rem % span[lvl-k];
      end
      res.level = 2'(lvl);
      res.first_ptr_index = PtrW'(ptr_idx[0]);
      res.second_ptr_index = PtrW'(ptr_idx[1]);
      res.third_ptr_index = PtrW'(ptr_idx[2]);
      res.entry_offset = OffW'(rem);
      return res;
    endfunction

    function void note_index(logic [IdxW-1:0] idx);
      pending.push_back(decompose(idx));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result beat %p", got);
        n_errors++;
        return;
      end
      want = pending.pop_front();
      n_checked++;
      if (want.overflow) n_overflow++;
      else level_seen[want.level]++;
      if (got.level !== want.level) begin
        $error("level: expected %0d, got %0d", want.level, got.level);
        n_errors++;
      end
      if (got.inode_slot !== want.inode_slot) begin
        $error("inode_slot: expected %0d, got %0d", want.inode_slot, got.inode_slot);
        n_errors++;
      end
      if (got.first_ptr_index !== want.first_ptr_index) begin
        $error("first_ptr_index: expected %0d, got %0d",
               want.first_ptr_index, got.first_ptr_index);
        n_errors++;
      end
      if (got.second_ptr_index !== want.second_ptr_index) begin
        $error("second_ptr_index: expected %0d, got %0d",
               want.second_ptr_index, got.second_ptr_index);
        n_errors++;
      end
      if (got.third_ptr_index !== want.third_ptr_index) begin
        $error("third_ptr_index: expected %0d, got %0d",
               want.third_ptr_index, got.third_ptr_index);
        n_errors++;
      end
      if (got.entry_offset !== want.entry_offset) begin
        $error("entry_offset: expected %0d, got %0d", want.entry_offset, got.entry_offset);
        n_errors++;
      end
      if (got.index_block_starts !== want.index_block_starts) begin
        $error("index_block_starts: expected %b, got %b",
               want.index_block_starts, got.index_block_starts);
        n_errors++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %b, got %b", want.overflow, got.overflow);
        n_errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ibid_if #(.payload_t(logic [IdxW-1:0])) idx_ch ();
  ibid_if #(.payload_t(result_t))         res_ch ();

  inode_block_index_decompose uut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (idx_ch.sink),
    .out_ch  (res_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  decompose_scoreboard board = new();

  // Sink side: receiver idling and the long hold-off that fills the pipeline.
  bit          hold_off;
  bit          sink_idle;
  bit          stim_done;
  int unsigned quiet_cycles;
  int unsigned n_sent;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idx_ch.valid = 1'b0;
    idx_ch.payload = '0;
    res_ch.ready = 1'b0;
    hold_off = 1'b0;
    sink_idle = 1'b0;
    stim_done = 1'b0;
  end

  // Result checking happens on the same edge that accepts the beat.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) board.check_result(res_ch.payload);
  end

  // Watchdog: counts cycles where neither channel moves a beat outside idle pauses.
  always @(posedge clk) begin
    if (rst || (idx_ch.valid && idx_ch.ready) || (res_ch.valid && res_ch.ready)
        || sink_idle) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("inode_block_index_decompose_tb: errors");
        $finish;
      end
    end
  end

  // Receiver: a random wait before each beat, with some stretches of none,
  // and a long hold-off when the sender asks for one.
  initial begin
    int unsigned gap;
    int unsigned calm;
    calm = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off) begin
        res_ch.ready <= 1'b0;
        repeat (LongStall) @(posedge clk);
        hold_off = 1'b0;
      end
      if (calm > 0) begin
        gap = 0;
        calm--;
      end else begin
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 30) == 0) calm = $urandom_range(20, 60);
      end
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid && !hold_off) @(posedge clk);
    end
  end

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == {RegBlockSizeKb, 2'b00}) board.kb_reg = value[KbW-1:0];
    else board.epb_reg = value[EpbW-1:0];
  endtask

  // Both registers change only once the pipeline is empty; the extra pause
  // covers any stage still holding a beat.
  task automatic set_geometry(input logic [31:0] kb, input logic [31:0] epb);
    while (board.pending.size() != 0) @(posedge clk);
    sink_idle = 1'b1;
    repeat (DrainCycles) @(posedge clk);
    write_reg({RegBlockSizeKb, 2'b00}, kb);
    write_reg({RegEntriesPerBlock, 2'b00}, epb);
    sink_idle = 1'b0;
  endtask

  // Offers one index; a gap of 0 keeps valid high into the next beat.
  task automatic send_index(input logic [IdxW-1:0] idx, input int unsigned gap);
    if (gap > 0) begin
      idx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    idx_ch.valid <= 1'b1;
    idx_ch.payload <= idx;
    @(posedge clk);
    while (!idx_ch.ready) @(posedge clk);
    board.note_index(idx);
    n_sent++;
  endtask

  // Region boundaries for the current geometry, used to aim random indexes
  // near the places where the level and the start flags change.
  function automatic logic [IdxW-1:0] near_boundary();
    longint unsigned kb, units, ptrs, span, edge_at, offs;
    int unsigned lvl;
    kb = board.kb_reg;
    units = board.epb_reg;
    if (kb < 1) kb = 1;
    if (kb > 16) kb = 16;
    if (units < 1) units = 1;
    if (units > 1024) units = 1024;
    ptrs = kb * 512;
    span = units;
    edge_at = units * NumDirect;
    lvl = $urandom_range(0, 3);
    for (int k = 0; k < lvl; k++) begin
      span = span * ptrs;
      edge_at = edge_at + span;
    end
    offs = $urandom_range(0, 3) == 0 ? 0 : longint'($urandom_range(0, 7)) * units;
    if ($urandom_range(0, 1)) edge_at = edge_at + offs;
    else if (edge_at >= offs) edge_at = edge_at - offs;
    if (edge_at > 64'hFFFF_FFFF) edge_at = {$urandom()};
    return IdxW'(edge_at);
  endfunction

  task automatic random_phase(input int unsigned count, input int unsigned max_gap);
    logic [IdxW-1:0] idx;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: idx = {$urandom()};
        1: idx = IdxW'($urandom_range(0, 20000));
        default: idx = near_boundary();
      endcase
      send_index(idx, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, max_gap));
    end
    idx_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [IdxW-1:0] directed[$];
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    n_sent = 0;
    @(posedge clk);

    // Directed part at reset geometry (512 pointers, one unit per block):
    // first and last direct, each indirect level's first and last unit,
    // the first overflowing index, all-ones and alternating bit patterns.
    directed = '{0, 7, 8, 9, 519, 520, 521, 1032, 262663, 262664, 262665,
                 134480391, 134480392, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
                 32'h5555_5555, 32'h0000_FFFF, 32'hFFFF_0000};
    foreach (directed[i]) send_index(directed[i], 0);
    idx_ch.valid <= 1'b0;

    // Register extremes, including the out-of-range values that clamp.
    set_geometry(0, 0);
    foreach (directed[i]) send_index(directed[i], $urandom_range(0, 2));
    idx_ch.valid <= 1'b0;
    set_geometry(16, 1024);
    send_index(0, 0);
    send_index(8191, 0);
    send_index(8192, 0);
    send_index(32'hFFFF_FFFF, 0);
    idx_ch.valid <= 1'b0;
    set_geometry(31, 2047);
    send_index(8192 + 1024, 1);
    send_index(32'h8000_0000, 0);
    idx_ch.valid <= 1'b0;

    // Random phases over several geometries.
    set_geometry(1, 1);
    random_phase(40, 8);

    // Pressure: stop the receiver for a long while and offer beats back to
    // back, more than the pipeline holds, so that the input stalls.
    hold_off = 1'b1;
    random_phase(150, 0);

    set_geometry(16, 1024);
    random_phase(50, 8);
    set_geometry($urandom_range(1, 16), $urandom_range(1, 1024));
    random_phase(50, 8);
    set_geometry($urandom_range(1, 4), $urandom_range(1, 16));
    random_phase(50, 8);
    set_geometry(1, 1024);
    random_phase(30, 8);

    while (board.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    $display("Checked %0d results of %0d indexes: direct %0d, single %0d, double %0d,",
             board.n_checked, n_sent, board.level_seen[0], board.level_seen[1],
             board.level_seen[2]);
    $display("  triple %0d, overflow %0d, over several block geometries.",
             board.level_seen[3], board.n_overflow);
    if (board.n_errors == 0 && board.pending.size() == 0) begin
      $display("inode_block_index_decompose_tb: clean");
    end else begin
      $display("inode_block_index_decompose_tb: errors");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/ibid_pkg.sv
rtl/core/ibid_if.sv
rtl/core/ibid_divider.sv
rtl/core/inode_block_index_decompose.sv
verif/inode_block_index_decompose_tb.sv
